### hw/rtl/skt_pkg.sv
package skt_pkg;

    localparam int DEPTH_DEF        = 1024;
    localparam int KEY_BITS_DEF     = 32;
    localparam int PAYLOAD_BITS_DEF = 32;

    // Field widths of the item and result transactions
    localparam int FUNC_W   = 3;
    localparam int KEY_W    = 32;
    localparam int PAY_W    = 32;
    localparam int POS_W    = 10;
    localparam int STATUS_W = 2;

    localparam logic [FUNC_W-1:0] FN_LOWER  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_INSERT = 3'd1;
    localparam logic [FUNC_W-1:0] FN_DELETE = 3'd2;
    localparam logic [FUNC_W-1:0] FN_READ   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_LINEAR = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [KEY_W-1:0]  key;
        logic [PAY_W-1:0]  payload;
        logic [POS_W-1:0]  position;
    } t_in_item;

    typedef struct packed {
        logic                found;
        logic [POS_W-1:0]    place;
        logic [KEY_W-1:0]    read_key;
        logic [PAY_W-1:0]    read_payload;
        logic [POS_W-1:0]    entries;
        logic [STATUS_W-1:0] status;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LB_RD,
        S_LB_CMP,
        S_INS_RD,
        S_INS_WR,
        S_DEL_RD,
        S_DEL_WR,
        S_LIN_RD,
        S_LIN_CMP,
        S_FETCH,
        S_RESULT
    } t_state;

endpackage

### hw/rtl/skt_store.sv
module skt_store #(
    parameter int DEPTH = skt_pkg::DEPTH_DEF,
    parameter int DW    = skt_pkg::KEY_BITS_DEF + skt_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DW-1:0]            i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DW-1:0]            o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Hold read data until the next read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/skt_seq.sv
module skt_seq #(
    parameter int DEPTH        = skt_pkg::DEPTH_DEF,
    parameter int KEY_BITS     = skt_pkg::KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = skt_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  skt_pkg::t_in_item     i_cmd,
    input  logic                  i_res_ready,
    output logic                  o_done,
    output skt_pkg::t_out_item    o_res,
    output logic                  o_we,
    output logic [$clog2(DEPTH)-1:0] o_waddr,
    output logic [((KEY_BITS < skt_pkg::KEY_W) ? KEY_BITS : skt_pkg::KEY_W) +
                  ((PAYLOAD_BITS < skt_pkg::PAY_W) ? PAYLOAD_BITS : skt_pkg::PAY_W) - 1:0]
                                  o_wdata,
    output logic                  o_re,
    output logic [$clog2(DEPTH)-1:0] o_raddr,
    input  logic [((KEY_BITS < skt_pkg::KEY_W) ? KEY_BITS : skt_pkg::KEY_W) +
                  ((PAYLOAD_BITS < skt_pkg::PAY_W) ? PAYLOAD_BITS : skt_pkg::PAY_W) - 1:0]
                                  i_rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int KW = (KEY_BITS < skt_pkg::KEY_W) ? KEY_BITS : skt_pkg::KEY_W;
    localparam int PW = (PAYLOAD_BITS < skt_pkg::PAY_W) ? PAYLOAD_BITS : skt_pkg::PAY_W;
    localparam int CW = (AW > skt_pkg::POS_W) ? AW : skt_pkg::POS_W;
    localparam logic [AW-1:0] FULL_COUNT = AW'(DEPTH - 1);

    skt_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_count, n_count;
    logic [skt_pkg::FUNC_W-1:0] r_func, n_func;
    logic [KW-1:0]   r_key, n_key;
    logic [PW-1:0]   r_pay, n_pay;
    logic [CW-1:0]   r_place, n_place;
    logic [AW-1:0]   r_lo, n_lo;
    logic [AW-1:0]   r_hi, n_hi;
    logic [AW-1:0]   r_mid, n_mid;
    logic [AW-1:0]   r_idx, n_idx;
    logic            r_found, n_found;
    logic            r_show, n_show;
    logic [skt_pkg::STATUS_W-1:0] r_status, n_status;

    logic [AW:0]     mid_sum;
    logic [CW-1:0]   pos_ext;
    logic [CW-1:0]   count_ext;
    logic [AW-1:0]   idx_inc;
    logic [KW-1:0]   rd_key;
    logic [PW-1:0]   rd_pay;
    logic            hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= skt_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_key    <= n_key;
        r_pay    <= n_pay;
        r_place  <= n_place;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_idx    <= n_idx;
        r_found  <= n_found;
        r_show   <= n_show;
        r_status <= n_status;
    end

    assign mid_sum   = {1'b0, r_lo} + {1'b0, r_hi};
    assign pos_ext   = CW'(i_cmd.position);
    assign count_ext = CW'(r_count);
    assign idx_inc   = r_idx + AW'(1);
    assign rd_key    = i_rdata[KW+PW-1:PW];
    assign rd_pay    = i_rdata[PW-1:0];
    assign hit       = r_show && (r_place < count_ext);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_func   = r_func;
        n_key    = r_key;
        n_pay    = r_pay;
        n_place  = r_place;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_idx    = r_idx;
        n_found  = r_found;
        n_show   = r_show;
        n_status = r_status;
        o_we     = 1'b0;
        o_waddr  = '0;
        o_wdata  = {r_key, r_pay};
        o_re     = 1'b0;
        o_raddr  = '0;
        o_done   = 1'b0;

        case (r_state)
            skt_pkg::S_IDLE: begin
                if (i_start) begin
                    n_func   = i_cmd.func;
                    n_key    = i_cmd.key[KW-1:0];
                    n_pay    = i_cmd.payload[PW-1:0];
                    n_found  = 1'b0;
                    n_show   = 1'b0;
                    n_status = skt_pkg::ST_OK;
                    n_place  = '0;
                    n_lo     = '0;
                    n_hi     = r_count;
                    n_state  = skt_pkg::S_FETCH;
                    case (i_cmd.func)
                        skt_pkg::FN_LOWER: begin
                            n_state = skt_pkg::S_LB_RD;
                        end
                        skt_pkg::FN_INSERT: begin
                            if (r_count >= FULL_COUNT) begin
                                n_status = skt_pkg::ST_FULL;
                            end else begin
                                n_state = skt_pkg::S_LB_RD;
                            end
                        end
                        skt_pkg::FN_DELETE: begin
                            n_place = pos_ext;
                            if (pos_ext >= count_ext) begin
                                n_status = skt_pkg::ST_RANGE;
                            end else begin
                                n_idx   = pos_ext[AW-1:0];
                                n_state = skt_pkg::S_DEL_RD;
                            end
                        end
                        skt_pkg::FN_READ: begin
                            n_place = pos_ext;
                            if (pos_ext >= count_ext) begin
                                n_status = skt_pkg::ST_RANGE;
                            end else begin
                                n_show = 1'b1;
                            end
                        end
                        skt_pkg::FN_LINEAR: begin
                            n_place = count_ext;
                            n_idx   = '0;
                            n_state = skt_pkg::S_LIN_RD;
                        end
                        default: begin
                            n_state = skt_pkg::S_FETCH;
                        end
                    endcase
                end
            end

            skt_pkg::S_LB_RD: begin
                if (r_lo < r_hi) begin
                    n_mid   = mid_sum[AW:1];
                    o_re    = 1'b1;
                    o_raddr = mid_sum[AW:1];
                    n_state = skt_pkg::S_LB_CMP;
                end else begin
                    n_place = CW'(r_lo);
                    if (r_func == skt_pkg::FN_INSERT) begin
                        n_idx   = r_count;
                        n_state = skt_pkg::S_INS_RD;
                    end else begin
                        n_show  = 1'b1;
                        n_state = skt_pkg::S_FETCH;
                    end
                end
            end

            skt_pkg::S_LB_CMP: begin
                if (rd_key >= r_key) begin
                    n_hi = r_mid;
                end else begin
                    n_lo = r_mid + AW'(1);
                end
                n_state = skt_pkg::S_LB_RD;
            end

            skt_pkg::S_INS_RD: begin
                if (r_idx > r_place[AW-1:0]) begin
                    o_re    = 1'b1;
                    o_raddr = r_idx - AW'(1);
                    n_state = skt_pkg::S_INS_WR;
                end else begin
                    // gap is open: drop the new record in
                    o_we    = 1'b1;
                    o_waddr = r_place[AW-1:0];
                    n_count = r_count + AW'(1);
                    n_found = 1'b1;
                    n_show  = 1'b1;
                    n_state = skt_pkg::S_FETCH;
                end
            end

            skt_pkg::S_INS_WR: begin
                o_we    = 1'b1;
                o_waddr = r_idx;
                o_wdata = i_rdata;
                n_idx   = r_idx - AW'(1);
                n_state = skt_pkg::S_INS_RD;
            end

            skt_pkg::S_DEL_RD: begin
                if (idx_inc < r_count) begin
                    o_re    = 1'b1;
                    o_raddr = idx_inc;
                    n_state = skt_pkg::S_DEL_WR;
                end else begin
                    n_count = r_count - AW'(1);
                    n_show  = 1'b1;
                    n_state = skt_pkg::S_FETCH;
                end
            end

            skt_pkg::S_DEL_WR: begin
                o_we    = 1'b1;
                o_waddr = r_idx;
                o_wdata = i_rdata;
                n_idx   = idx_inc;
                n_state = skt_pkg::S_DEL_RD;
            end

            skt_pkg::S_LIN_RD: begin
                if (r_idx < r_count) begin
                    o_re    = 1'b1;
                    o_raddr = r_idx;
                    n_state = skt_pkg::S_LIN_CMP;
                end else begin
                    n_state = skt_pkg::S_FETCH;
                end
            end

            skt_pkg::S_LIN_CMP: begin
                if (rd_key == r_key) begin
                    n_place = CW'(r_idx);
                    n_found = 1'b1;
                    n_show  = 1'b1;
                    n_state = skt_pkg::S_FETCH;
                end else begin
                    n_idx   = idx_inc;
                    n_state = skt_pkg::S_LIN_RD;
                end
            end

            skt_pkg::S_FETCH: begin
                if (hit) begin
                    o_re    = 1'b1;
                    o_raddr = r_place[AW-1:0];
                end
                n_state = skt_pkg::S_RESULT;
            end

            skt_pkg::S_RESULT: begin
                o_done = 1'b1;
                if (i_res_ready) begin
                    n_state = skt_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = skt_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_res.place        = r_place[skt_pkg::POS_W-1:0];
        o_res.entries      = count_ext[skt_pkg::POS_W-1:0];
        o_res.status       = r_status;
        o_res.read_key     = hit ? skt_pkg::KEY_W'(rd_key) : '0;
        o_res.read_payload = hit ? skt_pkg::PAY_W'(rd_pay) : '0;
        if (r_func == skt_pkg::FN_LOWER) begin
            o_res.found = hit && (rd_key == r_key);
        end else begin
            o_res.found = r_found;
        end
    end

endmodule

### hw/rtl/sorted_key_table_unit.sv
// Sorted key table: holds up to DEPTH-1 records (key, payload) in ascending key order in a
// single-port-per-direction memory of DEPTH slots, and serves one command per transaction:
// lower-bound binary search, insert at the lower bound (duplicates kept, refused with a full
// status at DEPTH-1 records), delete at a position, read at a position, and a linear exact
// search. Every input transaction yields exactly one result transaction. A command is worked
// by one sequencer and the memory, whose read data arrives in the cycle after the address: a
// binary search halves the range on each memory visit, an insert moves each record at or above
// the lower bound up one slot, a delete moves each record above the position down one slot,
// and a linear search scans record by record; then the reported entry is fetched and the
// result is presented. The input stalls from acceptance until the result is in the output
// register; that register lets the next transaction in while the previous result still waits
// on a stalled output. The memory comes out of reset unwritten and needs no clearing pass:
// only slots below the entry count are ever read.
module sorted_key_table_unit #(
    parameter int DEPTH        = skt_pkg::DEPTH_DEF,
    parameter int KEY_BITS     = skt_pkg::KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = skt_pkg::PAYLOAD_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  skt_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output skt_pkg::t_out_item o_out_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int KW = (KEY_BITS < skt_pkg::KEY_W) ? KEY_BITS : skt_pkg::KEY_W;
    localparam int PW = (PAYLOAD_BITS < skt_pkg::PAY_W) ? PAYLOAD_BITS : skt_pkg::PAY_W;
    localparam int DW = KW + PW;

    logic               r_busy, n_busy;
    logic               r_out_valid, n_out_valid;
    skt_pkg::t_out_item r_out_data;

    logic               in_take;
    logic               out_free;
    logic               res_load;
    logic               seq_done;
    skt_pkg::t_out_item seq_res;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [DW-1:0]      mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic [DW-1:0]      mem_rdata;

    // One command in flight; the input stalls until its result is registered
    assign in_take  = i_in_valid && !r_busy;
    assign out_free = !r_out_valid || !i_out_stall;
    assign res_load = seq_done && out_free;

    always_comb begin
        n_busy = r_busy;
        if (in_take) begin
            n_busy = 1'b1;
        end else if (res_load) begin
            n_busy = 1'b0;
        end

        // Hold a stalled result, drop it once taken, load a fresh one when free
        n_out_valid = r_out_valid && i_out_stall;
        if (res_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out_data <= seq_res;
        end
    end

    assign o_in_stall  = r_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    skt_seq #(
        .DEPTH        (DEPTH),
        .KEY_BITS     (KEY_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (in_take),
        .i_cmd       (i_in_data),
        .i_res_ready (out_free),
        .o_done      (seq_done),
        .o_res       (seq_res),
        .o_we        (mem_we),
        .o_waddr     (mem_waddr),
        .o_wdata     (mem_wdata),
        .o_re        (mem_re),
        .o_raddr     (mem_raddr),
        .i_rdata     (mem_rdata)
    );

    skt_store #(
        .DEPTH (DEPTH),
        .DW    (DW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

### hw/rtl/skt_checker.sv
module skt_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input skt_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input skt_pkg::t_out_item o_out_data
);

    // A taken transaction must close the input: the stall must be high right after the take
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input left open after a transaction was taken");

    // A result only appears while a command was in flight
    a_result_from_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared with no command in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    a_full_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == skt_pkg::ST_FULL)) |->
        (!o_out_data.found && (o_out_data.place == '0) &&
         (o_out_data.read_key == '0) && (o_out_data.read_payload == '0)))
        else $error("refused insert reported an entry");

    a_range_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == skt_pkg::ST_RANGE)) |->
        (!o_out_data.found && (o_out_data.read_key == '0) &&
         (o_out_data.read_payload == '0)))
        else $error("out-of-range position reported an entry");

endmodule

bind sorted_key_table_unit skt_checker u_skt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
